/* rtl/fss_pkg.sv */
// Shared types, cell codes and chance arithmetic for the forest-fire stencil.
// No dependencies; every other file imports this package.
package fss_pkg;

    // Cell codes
    localparam logic [2:0] CELL_WATER  = 3'd0;
    localparam logic [2:0] CELL_FOREST = 3'd1;
    localparam logic [2:0] CELL_CITY   = 3'd2;
    localparam logic [2:0] CELL_BURN0  = 3'd3;
    localparam logic [2:0] CELL_BURN1  = 3'd4;
    localparam logic [2:0] CELL_BURN2  = 3'd5;
    localparam logic [2:0] CELL_ASH    = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FOREST      = 2'd2;
    localparam logic [1:0] REG_CITY        = 2'd3;

    // Reset values of the configuration registers
    localparam logic [10:0] GRID_WIDTH_RESET  = 11'd500;
    localparam logic [10:0] GRID_HEIGHT_RESET = 11'd500;
    localparam logic [15:0] FOREST_RESET      = 16'd27525;
    localparam logic [15:0] CITY_RESET        = 16'd15729;

    localparam logic [20:0] COUNT_MAX   = 21'h1FFFFF;
    localparam int          QUEUE_DEPTH = 4;

    // Ignition chance for forest (entries 0..3) and city (4..7), 1..4 burning neighbors
    typedef logic [7:0][15:0] chance_table_t;

    // One cell to be updated, with its neighborhood already reduced
    typedef struct packed {
        logic [2:0]  center;
        logic [2:0]  burn_count;
        logic [15:0] draw_hi;     // draw in Q0.32, upper half
        logic        draw_lo_nz;  // draw in Q0.32, lower half not zero
        logic [9:0]  row;
        logic [9:0]  column;
        logic        row_done;
        logic        grid_done;
    } job_t;

    // What one accepted word leaves for the back end: up to two cells
    typedef struct packed {
        logic a_valid;
        job_t a;
        logic b_valid;
        job_t b;
    } pair_t;

    // Chance unit status toward the input side
    typedef struct packed {
        logic busy;
        logic pending;
    } chance_status_t;

    function automatic logic is_burning(input logic [2:0] code);
        return (code == CELL_BURN0) || (code == CELL_BURN1) || (code == CELL_BURN2);
    endfunction

    // One survival step: s * q with round half up, back to Q1.16
    function automatic logic [16:0] chance_step(input logic [16:0] s, input logic [16:0] q);
        logic [33:0] prod;
        prod = 34'(s) * 34'(q) + 34'd32768;
        return prod[32:16];
    endfunction

    // Chance from survival, saturated to 16 bits
    function automatic logic [15:0] chance_from_survival(input logic [16:0] s);
        logic [16:0] c;
        c = 17'h10000 - s;
        return c[16] ? 16'hFFFF : c[15:0];
    endfunction

    // Full table for a pair of chances; used for the reset value
    function automatic chance_table_t chance_rows(input logic [15:0] pf, input logic [15:0] pc);
        chance_table_t t;
        logic [16:0]   q;
        logic [16:0]   s;
        for (int h = 0; h < 2; h++)
        begin
            q = 17'h10000 - {1'b0, (h == 0) ? pf : pc};
            s = 17'h10000;
            for (int k = 0; k < 4; k++)
            begin
                s = chance_step(s, q);
                t[h * 4 + k] = chance_from_survival(s);
            end
        end
        return t;
    endfunction

endpackage

/* rtl/fss_chance.sv */
// Chance registers and the sequential unit that rebuilds the ignition table.
// Depends on fss_pkg.
module fss_chance
    import fss_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output chance_table_t  table_out,
    output chance_status_t status
);

    localparam chance_table_t TABLE_RESET = chance_rows(FOREST_RESET, CITY_RESET);

    logic [15:0]   forest_reg, forest_next;
    logic [15:0]   city_reg, city_next;
    logic          pend_forest_reg, pend_forest_next;
    logic          pend_city_reg, pend_city_next;
    logic          busy_reg, busy_next;
    logic          sel_reg, sel_next;
    logic [1:0]    step_reg, step_next;
    logic [16:0]   s_reg, s_next;
    logic [16:0]   q_reg, q_next;
    chance_table_t table_reg, table_next;
    logic [16:0]   s_step;

    // Sequence the four survival steps of one half of the table
    always_comb
    begin
        forest_next      = forest_reg;
        city_next        = city_reg;
        pend_forest_next = pend_forest_reg;
        pend_city_next   = pend_city_reg;
        busy_next        = busy_reg;
        sel_next         = sel_reg;
        step_next        = step_reg;
        s_next           = s_reg;
        q_next           = q_reg;
        table_next       = table_reg;
        s_step           = chance_step(s_reg, q_reg);

        if (busy_reg)
        begin
            table_next[{sel_reg, step_reg}] = chance_from_survival(s_step);
            s_next    = s_step;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end
        else if (pend_forest_reg || pend_city_reg)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            s_next    = 17'h10000;
            if (pend_forest_reg)
            begin
                sel_next         = 1'b0;
                q_next           = 17'h10000 - {1'b0, forest_reg};
                pend_forest_next = 1'b0;
            end
            else
            begin
                sel_next       = 1'b1;
                q_next         = 17'h10000 - {1'b0, city_reg};
                pend_city_next = 1'b0;
            end
        end

        // Latch new chances; a write always leaves a rebuild pending
        if (cfg_we && (cfg_index == REG_FOREST))
        begin
            forest_next      = cfg_data;
            pend_forest_next = 1'b1;
        end
        if (cfg_we && (cfg_index == REG_CITY))
        begin
            city_next      = cfg_data;
            pend_city_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forest_reg      <= FOREST_RESET;
            city_reg        <= CITY_RESET;
            pend_forest_reg <= 1'b0;
            pend_city_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            sel_reg         <= 1'b0;
            step_reg        <= 2'd0;
            table_reg       <= TABLE_RESET;
        end
        else
        begin
            forest_reg      <= forest_next;
            city_reg        <= city_next;
            pend_forest_reg <= pend_forest_next;
            pend_city_reg   <= pend_city_next;
            busy_reg        <= busy_next;
            sel_reg         <= sel_next;
            step_reg        <= step_next;
            table_reg       <= table_next;
        end
    end

    // Hold the multiplier operands
    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        q_reg <= q_next;
    end

    assign table_out      = table_reg;
    assign status.busy    = busy_reg;
    assign status.pending = pend_forest_reg || pend_city_reg;

endmodule

/* rtl/fss_front.sv */
// Front end: column window, raster position and neighbor classification.
// Turns each accepted word into up to two cell jobs. Depends on fss_pkg.
module fss_front
    import fss_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int DRAW_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [2:0]           cell_above,
    input  logic [2:0]           cell_center,
    input  logic [2:0]           cell_below,
    input  logic [DRAW_BITS-1:0] random_draw,
    input  logic [10:0]          grid_width,
    input  logic [10:0]          grid_height,
    output logic                 push,
    output pair_t                pair
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WZ  = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int HZ  = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [8:0]    win0_cells_reg;
    logic [15:0]   win0_hi_reg;
    logic          win0_lo_reg;
    logic [2:0]    win1_center_reg;

    logic [WZ-1:0] w_ext, w_clamp, w_last;
    logic [HZ-1:0] h_ext, h_clamp, h_last;
    logic          last_col, last_row, above_ok, below_ok;
    logic          col_ge1, col_ge2;
    logic [31:0]   draw_q32;
    logic [2:0]    prev_above, prev_center, prev_below;

    // Saturate the grid size and find the edges
    always_comb
    begin
        w_ext   = WZ'(grid_width);
        h_ext   = HZ'(grid_height);
        w_clamp = (w_ext == '0) ? WZ'(1) : ((w_ext > WZ'(MAX_WIDTH)) ? WZ'(MAX_WIDTH) : w_ext);
        h_clamp = (h_ext == '0) ? HZ'(1) : ((h_ext > HZ'(MAX_HEIGHT)) ? HZ'(MAX_HEIGHT) : h_ext);
        w_last  = w_clamp - WZ'(1);
        h_last  = h_clamp - HZ'(1);
        last_col = WZ'(col_reg) >= w_last;
        last_row = HZ'(row_reg) >= h_last;
        above_ok = row_reg != '0;
        below_ok = !last_row;
        col_ge1  = col_reg != '0;
        col_ge2  = {1'b0, col_reg} >= (CW + 1)'(2);
        draw_q32 = 32'(random_draw) << (32 - DRAW_BITS);
        prev_above  = win0_cells_reg[8:6];
        prev_center = win0_cells_reg[5:3];
        prev_below  = win0_cells_reg[2:0];
    end

    // Build the job for the previous cell and, at a row end, for this one
    always_comb
    begin
        pair.a_valid      = col_ge1;
        pair.a.center     = prev_center;
        pair.a.burn_count = 3'(above_ok && is_burning(prev_above))
                          + 3'(below_ok && is_burning(prev_below))
                          + 3'(col_ge2 && is_burning(win1_center_reg))
                          + 3'(is_burning(cell_center));
        pair.a.draw_hi    = win0_hi_reg;
        pair.a.draw_lo_nz = win0_lo_reg;
        pair.a.row        = 10'(row_reg);
        pair.a.column     = 10'(col_reg - CW'(1));
        pair.a.row_done   = 1'b0;
        pair.a.grid_done  = 1'b0;

        pair.b_valid      = last_col;
        pair.b.center     = cell_center;
        pair.b.burn_count = 3'(above_ok && is_burning(cell_above))
                          + 3'(below_ok && is_burning(cell_below))
                          + 3'(col_ge1 && is_burning(prev_center));
        pair.b.draw_hi    = draw_q32[31:16];
        pair.b.draw_lo_nz = |draw_q32[15:0];
        pair.b.row        = 10'(row_reg);
        pair.b.column     = 10'(col_reg);
        pair.b.row_done   = 1'b1;
        pair.b.grid_done  = last_row;

        push = accept && (col_ge1 || last_col);
    end

    // Advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            win0_cells_reg  <= '0;
            win0_hi_reg     <= '0;
            win0_lo_reg     <= 1'b0;
            win1_center_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            // Shift the column window
            if (accept)
            begin
                win0_cells_reg  <= {cell_above, cell_center, cell_below};
                win0_hi_reg     <= draw_q32[31:16];
                win0_lo_reg     <= |draw_q32[15:0];
                win1_center_reg <= prev_center;
            end
        end
    end

endmodule

/* rtl/fss_queue.sv */
// Short queue of job pairs between the front and back ends.
// Depends on fss_pkg.
module fss_queue
    import fss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pair_t push_data,
    input  logic  pop,
    output pair_t head,
    output logic  empty,
    output logic  full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    pair_t                 mem [QUEUE_DEPTH];
    logic [PW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]           count_reg, count_next;

    assign empty = count_reg == '0;
    assign full  = count_reg == (PW + 1)'(QUEUE_DEPTH);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (PW + 1)'(1);
            2'b01:   count_next = count_reg - (PW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // Store a pair
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/fss_back.sv */
// Back end: cell update rule, ignition test, running counts, output register.
// Depends on fss_pkg.
module fss_back
    import fss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pair_t         head,
    input  logic          empty,
    output logic          pop,
    input  chance_table_t chances,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    next_state,
    output logic [9:0]    out_row,
    output logic [9:0]    out_column,
    output logic          ignited,
    output logic          row_done,
    output logic          grid_done,
    output logic [20:0]   new_fire_total,
    output logic [20:0]   active_fire_total
);

    logic        half_reg, half_next;
    logic        valid_reg;
    logic [20:0] new_cnt_reg, new_cnt_next;
    logic [20:0] act_cnt_reg, act_cnt_next;
    logic [2:0]  state_reg;
    logic [9:0]  row_reg, column_reg;
    logic        lit_reg, row_done_reg, grid_done_reg;
    logic [20:0] new_tot_reg, act_tot_reg;

    job_t        job;
    logic        on_a, issue, second;
    logic        candidate, lit;
    logic [2:0]  state_next;
    logic [15:0] chance;
    logic [20:0] new_sum, act_sum;

    // Pick the job at the head and decide the issue
    always_comb
    begin
        on_a   = head.a_valid && !half_reg;
        job    = on_a ? head.a : head.b;
        issue  = !empty && (!valid_reg || out_ready);
        second = on_a && head.b_valid;
        pop    = issue && !second;
        half_next = half_reg;
        if (issue)
        begin
            half_next = second;
        end
    end

    // Apply the cell rule
    always_comb
    begin
        candidate  = (job.center == CELL_FOREST) || (job.center == CELL_CITY);
        chance     = chances[{job.center == CELL_CITY, 2'(job.burn_count - 3'd1)}];
        lit        = candidate && (job.burn_count != 3'd0) && (chance != 16'd0)
                   && ((job.draw_hi < chance)
                       || ((job.draw_hi == chance) && !job.draw_lo_nz));
        case (job.center)
            CELL_FOREST: state_next = lit ? CELL_BURN0 : CELL_FOREST;
            CELL_CITY:   state_next = lit ? CELL_BURN0 : CELL_CITY;
            CELL_BURN0:  state_next = CELL_BURN1;
            CELL_BURN1:  state_next = CELL_BURN2;
            CELL_BURN2:  state_next = CELL_ASH;
            CELL_ASH:    state_next = CELL_ASH;
            default:     state_next = CELL_WATER;
        endcase
        new_sum = (lit && (new_cnt_reg != COUNT_MAX)) ? new_cnt_reg + 21'd1 : new_cnt_reg;
        act_sum = (is_burning(state_next) && (act_cnt_reg != COUNT_MAX))
                ? act_cnt_reg + 21'd1 : act_cnt_reg;
        new_cnt_next = new_cnt_reg;
        act_cnt_next = act_cnt_reg;
        if (issue)
        begin
            // Drop the counts after the last cell of the generation
            new_cnt_next = job.grid_done ? '0 : new_sum;
            act_cnt_next = job.grid_done ? '0 : act_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            new_cnt_reg <= '0;
            act_cnt_reg <= '0;
        end
        else
        begin
            half_reg    <= half_next;
            new_cnt_reg <= new_cnt_next;
            act_cnt_reg <= act_cnt_next;
            if (issue)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            state_reg     <= state_next;
            row_reg       <= job.row;
            column_reg    <= job.column;
            lit_reg       <= lit;
            row_done_reg  <= job.row_done;
            grid_done_reg <= job.grid_done;
            new_tot_reg   <= new_sum;
            act_tot_reg   <= act_sum;
        end
    end

    assign out_valid         = valid_reg;
    assign next_state        = state_reg;
    assign out_row           = row_reg;
    assign out_column        = column_reg;
    assign ignited           = lit_reg;
    assign row_done          = row_done_reg;
    assign grid_done         = grid_done_reg;
    assign new_fire_total    = new_tot_reg;
    assign active_fire_total = act_tot_reg;

endmodule

/* rtl/fire_spread_stencil_step.sv */
// Forest-fire stencil, one generation. A cell's result passes from the word that completes
// its neighborhood via the queue to the output register; a row's last cell leaves after its
// left neighbor. Throughput: one column word per cycle while in_ready is high; config
// writes and a full queue hold input off, as does each chance write until the shared
// multiplier rebuilds four table entries. Reset (rst_n, async, active low) restores the
// size and chance registers and their table, clears the window, position, counts and queue.
module fire_spread_stencil_step
    import fss_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int DRAW_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           cell_above,
    input  logic [2:0]           cell_center,
    input  logic [2:0]           cell_below,
    input  logic [DRAW_BITS-1:0] random_draw,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           next_state,
    output logic [9:0]           out_row,
    output logic [9:0]           out_column,
    output logic                 ignited,
    output logic                 row_done,
    output logic                 grid_done,
    output logic [20:0]          new_fire_total,
    output logic [20:0]          active_fire_total
);

    logic [10:0]    grid_width_reg, grid_height_reg;
    chance_table_t  chances;
    chance_status_t chance_status;
    logic           accept, push, pop, q_empty, q_full;
    pair_t          push_pair, head_pair;

    // Hold the grid size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data[10:0];
            end
            if (cfg_index == REG_GRID_HEIGHT)
            begin
                grid_height_reg <= cfg_data[10:0];
            end
        end
    end

    // Take a word when the table is settled, no config write is present and the queue has room
    assign in_ready = !chance_status.busy && !chance_status.pending && !cfg_we && !q_full;
    assign accept   = in_valid && in_ready;

    fss_chance u_chance
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .table_out (chances),
        .status    (chance_status)
    );

    fss_front
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DRAW_BITS  (DRAW_BITS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cell_above  (cell_above),
        .cell_center (cell_center),
        .cell_below  (cell_below),
        .random_draw (random_draw),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .push        (push),
        .pair        (push_pair)
    );

    fss_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_pair),
        .pop       (pop),
        .head      (head_pair),
        .empty     (q_empty),
        .full      (q_full)
    );

    fss_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head_pair),
        .empty             (q_empty),
        .pop               (pop),
        .chances           (chances),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .next_state        (next_state),
        .out_row           (out_row),
        .out_column        (out_column),
        .ignited           (ignited),
        .row_done          (row_done),
        .grid_done         (grid_done),
        .new_fire_total    (new_fire_total),
        .active_fire_total (active_fire_total)
    );

endmodule

/* rtl/fss_checker.sv */
// Port-level checks on the result channel of the forest-fire stencil.
// Depends on fss_pkg; bound to fire_spread_stencil_step below.
module fss_checker
    import fss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  next_state,
    input logic        ignited,
    input logic        row_done,
    input logic        grid_done,
    input logic [20:0] new_fire_total,
    input logic [20:0] active_fire_total
);

    // A stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_state) && $stable(new_fire_total))
        else $error("result word changed while stalled");

    // The generation ends on a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_done |-> row_done)
        else $error("grid_done without row_done");

    // A new fire starts at the first burning age
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ignited |-> next_state == CELL_BURN0)
        else $error("ignited cell not at burning age 0");

    // Every ignition is also an active fire
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> new_fire_total <= active_fire_total)
        else $error("new fire count above active fire count");

endmodule

bind fire_spread_stencil_step fss_checker u_fss_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .next_state        (next_state),
    .ignited           (ignited),
    .row_done          (row_done),
    .grid_done         (grid_done),
    .new_fire_total    (new_fire_total),
    .active_fire_total (active_fire_total)
);
